// ===== design/tcre_pkg.sv =====
// shared constants, register indexes and controller interface types for the touch event block
package tcre_pkg;

   // field widths
   localparam int RAW_W      = 12;
   localparam int SIZE_W     = 10;
   localparam int TIME_W     = 32;
   localparam int LONG_W     = 16;
   localparam int DIFF_W     = RAW_W + 1;
   localparam int PROD_W     = RAW_W + SIZE_W;
   localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_X_MIN      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_MAX      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_MIN      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_MAX      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SWAP_AXES  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS = 4'd7;

   // thresholds and reset values
   localparam logic [RAW_W-1:0]  PRESSURE_MIN  = 12'd200;
   localparam logic [RAW_W-1:0]  CAL_MIN_RESET = 12'd350;
   localparam logic [RAW_W-1:0]  CAL_MAX_RESET = 12'd3700;
   localparam logic              SWAP_RESET    = 1'b1;
   localparam logic [SIZE_W-1:0] WIDTH_RESET   = 10'd320;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET  = 10'd240;
   localparam logic [LONG_W-1:0] LONG_RESET    = 16'd600;

   // controller to datapath
   typedef struct packed {
      logic sample_load;
      logic mul_load;
      logic div_start;
      logic pos_update;
      logic emit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sample_valid;
      logic pressing;
      logic div_done;
      logic out_free;
   } ctrl_status_type;

endpackage

// ===== design/tcre_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
module tcre_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tcre_pkg::PROD_W-1:0]   dividend,
   input  logic [tcre_pkg::RAW_W-1:0]    divisor,
   output logic                          busy,
   output logic [tcre_pkg::PROD_W-1:0]   quotient
);

   logic                             busy_ff, busy_in;
   logic [tcre_pkg::DIV_CNT_W-1:0]   count_ff, count_in;
   logic [tcre_pkg::PROD_W-1:0]      quot_ff, quot_in;
   logic [tcre_pkg::RAW_W-1:0]       rem_ff, rem_in;
   logic [tcre_pkg::RAW_W:0]         shifted;
   logic [tcre_pkg::RAW_W-1:0]       trial;
   logic                             fits;

   // one trial subtraction per step; when it fits the difference is below the divisor
   assign shifted = {rem_ff, quot_ff[tcre_pkg::PROD_W-1]};
   assign fits    = shifted >= {1'b0, divisor};
   assign trial   = shifted[tcre_pkg::RAW_W-1:0] - divisor;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = tcre_pkg::DIV_CNT_W'(tcre_pkg::PROD_W);
         quot_in  = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         count_in = count_ff - 1'b1;
         if (count_ff == tcre_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
         if (fits) begin
            rem_in  = trial;
            quot_in = {quot_ff[tcre_pkg::PROD_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[tcre_pkg::RAW_W-1:0];
            quot_in = {quot_ff[tcre_pkg::PROD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// ===== design/tcre_ctrl.sv =====
// sequencing state machine for one touch sample at a time
module tcre_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tcre_pkg::ctrl_status_type  status,
   output tcre_pkg::ctrl_cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EVAL  = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.sample_load = 1'b1;
               state_in        = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.sample_valid) begin
               cmd.mul_load = 1'b1;
               state_in     = ST_START;
            end else if (status.pressing) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.pos_update = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ===== design/tcre_datapath.sv =====
// config registers, sample capture, axis mapping lanes, press tracking and result register
module tcre_datapath (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_valid,
   input  logic [tcre_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcre_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // sample
   input  logic                              req_pen_down,
   input  logic [tcre_pkg::RAW_W-1:0]        req_raw_x,
   input  logic [tcre_pkg::RAW_W-1:0]        req_raw_y,
   input  logic [tcre_pkg::RAW_W-1:0]        req_pressure,
   input  logic [tcre_pkg::TIME_W-1:0]       req_now_ms,
   // result
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tcre_pkg::SIZE_W-1:0]       rsp_event_x,
   output logic [tcre_pkg::SIZE_W-1:0]       rsp_event_y,
   output logic [tcre_pkg::TIME_W-1:0]       rsp_duration_ms,
   output logic                              rsp_long_press,
   // controller
   input  tcre_pkg::ctrl_cmd_type            cmd,
   output tcre_pkg::ctrl_status_type         status
);

   localparam int RW = tcre_pkg::RAW_W;
   localparam int SW = tcre_pkg::SIZE_W;
   localparam int TW = tcre_pkg::TIME_W;
   localparam int DW = tcre_pkg::DIFF_W;
   localparam int PW = tcre_pkg::PROD_W;

   // configuration registers
   logic [RW-1:0]              x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic                       swap_ff;
   logic [SW-1:0]              width_ff, height_ff;
   logic [tcre_pkg::LONG_W-1:0] long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff  <= tcre_pkg::CAL_MIN_RESET;
         x_max_ff  <= tcre_pkg::CAL_MAX_RESET;
         y_min_ff  <= tcre_pkg::CAL_MIN_RESET;
         y_max_ff  <= tcre_pkg::CAL_MAX_RESET;
         swap_ff   <= tcre_pkg::SWAP_RESET;
         width_ff  <= tcre_pkg::WIDTH_RESET;
         height_ff <= tcre_pkg::HEIGHT_RESET;
         long_ff   <= tcre_pkg::LONG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tcre_pkg::REG_X_MIN:      x_min_ff  <= csr_wdata[RW-1:0];
            tcre_pkg::REG_X_MAX:      x_max_ff  <= csr_wdata[RW-1:0];
            tcre_pkg::REG_Y_MIN:      y_min_ff  <= csr_wdata[RW-1:0];
            tcre_pkg::REG_Y_MAX:      y_max_ff  <= csr_wdata[RW-1:0];
            tcre_pkg::REG_SWAP_AXES:  swap_ff   <= csr_wdata[0];
            tcre_pkg::REG_WIDTH:      width_ff  <= csr_wdata[SW-1:0];
            tcre_pkg::REG_HEIGHT:     height_ff <= csr_wdata[SW-1:0];
            tcre_pkg::REG_LONG_PRESS: long_ff   <= csr_wdata[tcre_pkg::LONG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sample capture
   logic          pen_ff;
   logic [RW-1:0] raw_x_ff, raw_y_ff, press_ff;
   logic [TW-1:0] now_ff;

   always_ff @(posedge clock) begin
      if (cmd.sample_load) begin
         pen_ff   <= req_pen_down;
         raw_x_ff <= req_raw_x;
         raw_y_ff <= req_raw_y;
         press_ff <= req_pressure;
         now_ff   <= req_now_ms;
      end
   end

   logic sample_valid;
   assign sample_valid = pen_ff && (press_ff >= tcre_pkg::PRESSURE_MIN);

   // mapping front end: signed difference and span, magnitude product
   logic [RW-1:0] for_x, for_y;
   logic [DW-1:0] diff_x, diff_y, span_x, span_y;
   logic [RW-1:0] adiff_x, adiff_y, aspan_x, aspan_y;
   logic [SW-1:0] size_x, size_y;

   assign for_x  = swap_ff ? raw_y_ff : raw_x_ff;
   assign for_y  = swap_ff ? raw_x_ff : raw_y_ff;
   assign diff_x = {1'b0, for_x} - {1'b0, x_min_ff};
   assign diff_y = {1'b0, for_y} - {1'b0, y_min_ff};
   assign span_x = ({1'b0, x_max_ff} == {1'b0, x_min_ff}) ? DW'(1)
                 : ({1'b0, x_max_ff} - {1'b0, x_min_ff});
   assign span_y = ({1'b0, y_max_ff} == {1'b0, y_min_ff}) ? DW'(1)
                 : ({1'b0, y_max_ff} - {1'b0, y_min_ff});
   assign adiff_x = diff_x[DW-1] ? RW'(-diff_x) : diff_x[RW-1:0];
   assign adiff_y = diff_y[DW-1] ? RW'(-diff_y) : diff_y[RW-1:0];
   assign aspan_x = span_x[DW-1] ? RW'(-span_x) : span_x[RW-1:0];
   assign aspan_y = span_y[DW-1] ? RW'(-span_y) : span_y[RW-1:0];
   assign size_x  = (width_ff == '0) ? SW'(1) : width_ff;
   assign size_y  = (height_ff == '0) ? SW'(1) : height_ff;

   logic [PW-1:0] prod_x_ff, prod_y_ff;
   logic [RW-1:0] div_x_ff, div_y_ff;
   logic [SW-1:0] size_x_ff, size_y_ff;
   logic          neg_x_ff, neg_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         prod_x_ff <= PW'(adiff_x) * PW'(size_x);
         prod_y_ff <= PW'(adiff_y) * PW'(size_y);
         div_x_ff  <= aspan_x;
         div_y_ff  <= aspan_y;
         size_x_ff <= size_x;
         size_y_ff <= size_y;
         neg_x_ff  <= diff_x[DW-1] ^ span_x[DW-1];
         neg_y_ff  <= diff_y[DW-1] ^ span_y[DW-1];
      end
   end

   // one divider lane per axis
   logic          busy_x, busy_y;
   logic [PW-1:0] quot_x, quot_y;

   tcre_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_x_ff),
      .divisor  (div_x_ff),
      .busy     (busy_x),
      .quotient (quot_x)
   );

   tcre_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_y_ff),
      .divisor  (div_y_ff),
      .busy     (busy_y),
      .quotient (quot_y)
   );

   // clamp to 0..size-1; a negative quotient clamps to zero
   logic [SW-1:0] pos_x, pos_y;

   assign pos_x = neg_x_ff ? '0
                : (quot_x >= PW'(size_x_ff)) ? (size_x_ff - 1'b1) : quot_x[SW-1:0];
   assign pos_y = neg_y_ff ? '0
                : (quot_y >= PW'(size_y_ff)) ? (size_y_ff - 1'b1) : quot_y[SW-1:0];

   // press tracking
   logic          pressing_ff;
   logic [TW-1:0] start_ff;
   logic [SW-1:0] last_x_ff, last_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pressing_ff <= 1'b0;
         start_ff    <= '0;
         last_x_ff   <= '0;
         last_y_ff   <= '0;
      end else if (cmd.pos_update) begin
         last_x_ff <= pos_x;
         last_y_ff <= pos_y;
         if (!pressing_ff) begin
            pressing_ff <= 1'b1;
            start_ff    <= now_ff;
         end
      end else if (cmd.emit) begin
         pressing_ff <= 1'b0;
      end
   end

   // result word register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] ev_x_ff, ev_y_ff;
   logic [TW-1:0] dur_ff;
   logic          long_flag_ff;
   logic [TW-1:0] duration;
   logic          out_free;

   assign duration = now_ff - start_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         ev_x_ff      <= last_x_ff;
         ev_y_ff      <= last_y_ff;
         dur_ff       <= duration;
         long_flag_ff <= (duration >= TW'(long_ff));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_x     = ev_x_ff;
   assign rsp_event_y     = ev_y_ff;
   assign rsp_duration_ms = dur_ff;
   assign rsp_long_press  = long_flag_ff;

   // status back to the controller
   assign status.sample_valid = sample_valid;
   assign status.pressing     = pressing_ff;
   assign status.div_done     = !busy_x && !busy_y;
   assign status.out_free     = out_free;

endmodule

// ===== design/touch_calibrate_and_release_event_top.sv =====
// top level of the touch calibration and release event block
//
// Usage: one touch sample word enters on the req_ channel (pen-down flag, raw X/Y,
// pressure, millisecond time stamp). A sample with pen down and pressure of at
// least 200 is mapped to screen coordinates and remembered; the first weak or
// pen-up sample after a press sends one release word on the rsp_ channel with
// the last position, the press duration and a long-press flag.
// The csr_ channel writes the eight calibration registers by index; it is
// always ready. The user makes writes only while the block is idle; the
// block itself does not enforce it. A touch sample passes the idle, evaluate,
// start and divide states, the last held by the two 22-step restoring
// dividers that run side by side, one per axis; a release sample passes idle,
// evaluate and emit, an ignored one idle and evaluate. The release word sits
// in an output register; the block keeps accepting samples while it waits,
// and only a second release stalls until the receiver takes the first one.
// Reset: calibration registers return to their defaults, no press is active
// and no result is pending.
module touch_calibrate_and_release_event_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tcre_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcre_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_pen_down,
   input  logic [tcre_pkg::RAW_W-1:0]        req_raw_x,
   input  logic [tcre_pkg::RAW_W-1:0]        req_raw_y,
   input  logic [tcre_pkg::RAW_W-1:0]        req_pressure,
   input  logic [tcre_pkg::TIME_W-1:0]       req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tcre_pkg::SIZE_W-1:0]       rsp_event_x,
   output logic [tcre_pkg::SIZE_W-1:0]       rsp_event_y,
   output logic [tcre_pkg::TIME_W-1:0]       rsp_duration_ms,
   output logic                              rsp_long_press
);

   tcre_pkg::ctrl_cmd_type    cmd;
   tcre_pkg::ctrl_status_type status;

   assign csr_ready = 1'b1;

   // sequencing
   tcre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   tcre_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_pen_down    (req_pen_down),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .req_pressure    (req_pressure),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_x     (rsp_event_x),
      .rsp_event_y     (rsp_event_y),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_long_press  (rsp_long_press),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ===== dv/tb.sv =====
// testbench for the touch calibration and release event block
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAW_W          = tcre_pkg::RAW_W;
   localparam int SIZE_W         = tcre_pkg::SIZE_W;
   localparam int TIME_W         = tcre_pkg::TIME_W;
   localparam int LONG_W         = tcre_pkg::LONG_W;
   localparam int CSR_IDX_W      = tcre_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W     = tcre_pkg::CSR_DATA_W;
   localparam int RAW_MAX        = (1 << RAW_W) - 1;
   localparam int SIZE_MAX       = (1 << SIZE_W) - 1;
   localparam int LONG_MAX       = (1 << LONG_W) - 1;
   localparam int IDX_MAX        = (1 << CSR_IDX_W) - 1;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic              pen_down;
      logic [RAW_W-1:0]  raw_x;
      logic [RAW_W-1:0]  raw_y;
      logic [RAW_W-1:0]  pressure;
      logic [TIME_W-1:0] now_ms;
   } touch_sample_type;

   typedef struct packed {
      logic [SIZE_W-1:0] x;
      logic [SIZE_W-1:0] y;
      logic [TIME_W-1:0] duration;
      logic              long_press;
   } release_event_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_pen_down = 1'b0;
   logic [RAW_W-1:0]      req_raw_x = '0;
   logic [RAW_W-1:0]      req_raw_y = '0;
   logic [RAW_W-1:0]      req_pressure = '0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SIZE_W-1:0]     rsp_event_x;
   logic [SIZE_W-1:0]     rsp_event_y;
   logic [TIME_W-1:0]     rsp_duration_ms;
   logic                  rsp_long_press;

   touch_calibrate_and_release_event_top DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pen_down    (req_pen_down),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .req_pressure    (req_pressure),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_x     (rsp_event_x),
      .rsp_event_y     (rsp_event_y),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_long_press  (rsp_long_press)
   );

   initial forever #2 clock = ~clock;

   // shadow copy of the calibration registers
   logic [RAW_W-1:0]  cfg_x_min  = tcre_pkg::CAL_MIN_RESET;
   logic [RAW_W-1:0]  cfg_x_max  = tcre_pkg::CAL_MAX_RESET;
   logic [RAW_W-1:0]  cfg_y_min  = tcre_pkg::CAL_MIN_RESET;
   logic [RAW_W-1:0]  cfg_y_max  = tcre_pkg::CAL_MAX_RESET;
   logic              cfg_swap   = tcre_pkg::SWAP_RESET;
   logic [SIZE_W-1:0] cfg_width  = tcre_pkg::WIDTH_RESET;
   logic [SIZE_W-1:0] cfg_height = tcre_pkg::HEIGHT_RESET;
   logic [LONG_W-1:0] cfg_long   = tcre_pkg::LONG_RESET;

   // tracked touch state
   logic              press_active   = 1'b0;
   logic [TIME_W-1:0] press_begin_ms = '0;
   logic [SIZE_W-1:0] last_col       = '0;
   logic [SIZE_W-1:0] last_row       = '0;

   touch_sample_type  pending_samples[$];
   release_event_type release_q[$];
   touch_sample_type  held_sample;
   int             mismatches   = 0;
   int             req_gap      = 0;
   int             rsp_stall    = 0;
   int             req_idle_pct = 20;
   int             rsp_idle_pct = 20;
   int             quiet_cycles = 0;
   logic [TIME_W-1:0] sample_ms = 32'd10000;

   // linear map of one raw axis onto the screen, clamped to the screen
   function automatic logic [SIZE_W-1:0] scale_axis(input logic [RAW_W-1:0] raw,
                                                    input logic [RAW_W-1:0] lo,
                                                    input logic [RAW_W-1:0] hi,
                                                    input logic [SIZE_W-1:0] size);
      int span;
      int sz;
      int v;
      span = int'(hi) - int'(lo);
      sz   = int'(size);
      if (span == 0) span = 1;
      if (sz == 0) sz = 1;
      v = (int'(raw) - int'(lo)) * sz / span;
      if (v < 0) v = 0;
      else if (v >= sz) v = sz - 1;
      return SIZE_W'(v);
   endfunction

   // update shadow registers on a write; unknown indexes are dropped
   function automatic void store_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         tcre_pkg::REG_X_MIN:      cfg_x_min  = data[RAW_W-1:0];
         tcre_pkg::REG_X_MAX:      cfg_x_max  = data[RAW_W-1:0];
         tcre_pkg::REG_Y_MIN:      cfg_y_min  = data[RAW_W-1:0];
         tcre_pkg::REG_Y_MAX:      cfg_y_max  = data[RAW_W-1:0];
         tcre_pkg::REG_SWAP_AXES:  cfg_swap   = data[0];
         tcre_pkg::REG_WIDTH:      cfg_width  = data[SIZE_W-1:0];
         tcre_pkg::REG_HEIGHT:     cfg_height = data[SIZE_W-1:0];
         tcre_pkg::REG_LONG_PRESS: cfg_long   = data[LONG_W-1:0];
         default: ;
      endcase
   endfunction

   // follow one accepted sample and queue the release word it causes
   function automatic void track_sample(input touch_sample_type s);
      logic [RAW_W-1:0]  col_raw;
      logic [RAW_W-1:0]  row_raw;
      release_event_type ev;
      if (s.pen_down && s.pressure >= tcre_pkg::PRESSURE_MIN) begin
         col_raw  = cfg_swap ? s.raw_y : s.raw_x;
         row_raw  = cfg_swap ? s.raw_x : s.raw_y;
         last_col = scale_axis(col_raw, cfg_x_min, cfg_x_max, cfg_width);
         last_row = scale_axis(row_raw, cfg_y_min, cfg_y_max, cfg_height);
         if (!press_active) begin
            press_active   = 1'b1;
            press_begin_ms = s.now_ms;
         end
      end else if (press_active) begin
         press_active  = 1'b0;
         ev.x          = last_col;
         ev.y          = last_row;
         ev.duration   = s.now_ms - press_begin_ms;
         ev.long_press = (ev.duration >= {{(TIME_W-LONG_W){1'b0}}, cfg_long});
         release_q.push_back(ev);
      end
   endfunction

   function automatic void push_sample(input logic pen, input logic [RAW_W-1:0] x,
                                       input logic [RAW_W-1:0] y,
                                       input logic [RAW_W-1:0] p,
                                       input logic [TIME_W-1:0] t);
      touch_sample_type s;
      s.pen_down = pen;
      s.raw_x    = x;
      s.raw_y    = y;
      s.pressure = p;
      s.now_ms   = t;
      pending_samples.push_back(s);
   endfunction

   function automatic logic [RAW_W-1:0] rand_raw();
      case ($urandom_range(7))
         0: return '0;
         1: return RAW_W'(RAW_MAX);
         default: return RAW_W'($urandom_range(RAW_MAX));
      endcase
   endfunction

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) track_sample(held_sample);
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0 && req_idle_pct != 0 &&
                         $urandom_range(99) < req_idle_pct) begin
               req_gap = $urandom_range(16);
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               held_sample = pending_samples.pop_front();
               req_pen_down <= held_sample.pen_down;
               req_raw_x    <= held_sample.raw_x;
               req_raw_y    <= held_sample.raw_y;
               req_pressure <= held_sample.pressure;
               req_now_ms   <= held_sample.now_ms;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // release word monitor with random back-pressure
   always @(posedge clock) begin
      release_event_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (release_q.size() == 0) begin
               $error("unexpected release word x=%0d y=%0d", rsp_event_x, rsp_event_y);
               mismatches++;
            end else begin
               want = release_q.pop_front();
               if (rsp_event_x !== want.x) begin
                  $error("event_x: expected %0d, actual %0d", want.x, rsp_event_x);
                  mismatches++;
               end
               if (rsp_event_y !== want.y) begin
                  $error("event_y: expected %0d, actual %0d", want.y, rsp_event_y);
                  mismatches++;
               end
               if (rsp_duration_ms !== want.duration) begin
                  $error("duration_ms: expected %0d, actual %0d", want.duration,
                         rsp_duration_ms);
                  mismatches++;
               end
               if (rsp_long_press !== want.long_press) begin
                  $error("long_press: expected %0d, actual %0d", want.long_press,
                         rsp_long_press);
                  mismatches++;
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_idle_pct != 0 && $urandom_range(99) < rsp_idle_pct) begin
            rsp_stall = $urandom_range(16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no accepted word anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("touch_calibrate_and_release_event_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one register write; valid stays up for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      store_reg(idx, data);
   endtask

   // full register set, preceded by a write to an unmapped index
   task automatic apply_settings(input logic [RAW_W-1:0] xmin, input logic [RAW_W-1:0] xmax,
                                 input logic [RAW_W-1:0] ymin, input logic [RAW_W-1:0] ymax,
                                 input logic swap, input logic [SIZE_W-1:0] w,
                                 input logic [SIZE_W-1:0] h, input logic [LONG_W-1:0] lp);
      write_reg(CSR_IDX_W'($urandom_range(tcre_pkg::REG_LONG_PRESS + 1, IDX_MAX)),
                CSR_DATA_W'($urandom));
      write_reg(tcre_pkg::REG_X_MIN, CSR_DATA_W'(xmin));
      write_reg(tcre_pkg::REG_X_MAX, CSR_DATA_W'(xmax));
      write_reg(tcre_pkg::REG_Y_MIN, CSR_DATA_W'(ymin));
      write_reg(tcre_pkg::REG_Y_MAX, CSR_DATA_W'(ymax));
      write_reg(tcre_pkg::REG_SWAP_AXES, CSR_DATA_W'(swap));
      write_reg(tcre_pkg::REG_WIDTH, CSR_DATA_W'(w));
      write_reg(tcre_pkg::REG_HEIGHT, CSR_DATA_W'(h));
      write_reg(tcre_pkg::REG_LONG_PRESS, CSR_DATA_W'(lp));
      csr_valid <= 1'b0;
   endtask

   // wait until every word is through, then let the datapath settle
   task automatic drain();
      @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || release_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly complete presses with random content, some raw noise
   task automatic gen_traffic(input int n_items);
      int made;
      int taps;
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] hold;
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(99) < 75) begin
            t0 = ($urandom_range(9) == 0) ? TIME_W'($urandom) : sample_ms;
            case ($urandom_range(3))
               0: hold = TIME_W'($urandom_range(2000));
               1: hold = {{(TIME_W-LONG_W){1'b0}}, cfg_long} + TIME_W'($urandom_range(2)) - 1;
               2: hold = TIME_W'($urandom);
               default: hold = TIME_W'($urandom_range(40));
            endcase
            taps = $urandom_range(1, 6);
            for (int i = 0; i < taps; i++)
               push_sample(1'b1, rand_raw(), rand_raw(),
                           RAW_W'($urandom_range(tcre_pkg::PRESSURE_MIN, RAW_MAX)),
                           t0 + TIME_W'(i));
            // lift: pen up, or pen down with too little pressure
            if ($urandom_range(1) == 0)
               push_sample(1'b0, rand_raw(), rand_raw(), RAW_W'($urandom_range(RAW_MAX)),
                           t0 + hold);
            else
               push_sample(1'b1, rand_raw(), rand_raw(),
                           RAW_W'($urandom_range(tcre_pkg::PRESSURE_MIN - 1)), t0 + hold);
            made += taps + 1;
            sample_ms = t0 + hold + TIME_W'($urandom_range(1, 500));
         end else begin
            push_sample(1'($urandom_range(1)), RAW_W'($urandom), RAW_W'($urandom),
                        RAW_W'($urandom), TIME_W'($urandom));
            made++;
         end
      end
   endtask

   // main sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset settings
      push_sample(1'b0, RAW_W'(RAW_MAX), RAW_W'(RAW_MAX), RAW_W'(RAW_MAX), 32'd10);
      push_sample(1'b1, 12'd2000, 12'd2000, RAW_W'(tcre_pkg::PRESSURE_MIN - 1), 32'd20);
      push_sample(1'b1, 12'd0, 12'd0, tcre_pkg::PRESSURE_MIN, 32'd1000);
      push_sample(1'b1, RAW_W'(RAW_MAX), RAW_W'(RAW_MAX), RAW_W'(RAW_MAX), 32'd1100);
      push_sample(1'b0, 12'd100, 12'd100, RAW_W'(RAW_MAX), 32'd1599);
      push_sample(1'b1, tcre_pkg::CAL_MIN_RESET, tcre_pkg::CAL_MAX_RESET, RAW_W'(RAW_MAX),
                  32'd2000);
      push_sample(1'b1, 12'd0, 12'd0, RAW_W'(tcre_pkg::PRESSURE_MIN - 1), 32'd2600);
      push_sample(1'b1, RAW_W'(RAW_MAX), 12'd0, 12'd500, 32'hFFFF_FF00);
      push_sample(1'b0, 12'd0, 12'd0, 12'd0, 32'h0000_0100);
      push_sample(1'b1, 12'd1500, 12'd2500, 12'd300, 32'd5);
      push_sample(1'b0, 12'd0, 12'd0, 12'd0, 32'd5);
      push_sample(1'b1, 12'd2025, 12'd2025, 12'd1000, 32'd0);
      push_sample(1'b0, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF);
      push_sample(1'b1, RAW_W'(tcre_pkg::CAL_MIN_RESET - 1),
                  RAW_W'(tcre_pkg::CAL_MAX_RESET + 1), 12'd800, 32'd100);
      push_sample(1'b1, 12'd1, RAW_W'(RAW_MAX - 1), 12'd800, 32'd200);
      push_sample(1'b0, 12'd0, 12'd0, 12'd0, 32'd700);
      drain();

      // full raw range, mirrored Y, widest and narrowest screen, zero threshold
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      apply_settings('0, RAW_W'(RAW_MAX), RAW_W'(RAW_MAX), '0, 1'b0, SIZE_W'(SIZE_MAX),
                     SIZE_W'(1), '0);
      gen_traffic(105);
      drain();

      // zero span on X, zero screen size, highest threshold
      req_idle_pct = 0;
      rsp_idle_pct = 50;
      apply_settings(12'd2000, 12'd2000, 12'd100, 12'd200, 1'b1, '0, '0, LONG_W'(LONG_MAX));
      gen_traffic(105);
      drain();

      // plausible random calibration
      req_idle_pct = 50;
      rsp_idle_pct = 0;
      apply_settings(RAW_W'($urandom_range(1000)), RAW_W'($urandom_range(3000, RAW_MAX)),
                     RAW_W'($urandom_range(1000)), RAW_W'($urandom_range(3000, RAW_MAX)),
                     1'($urandom_range(1)), SIZE_W'($urandom_range(1, SIZE_MAX)),
                     SIZE_W'($urandom_range(1, SIZE_MAX)), LONG_W'($urandom_range(3000)));
      gen_traffic(105);
      drain();

      // anything goes
      req_idle_pct = 15;
      rsp_idle_pct = 15;
      apply_settings(rand_raw(), rand_raw(), rand_raw(), rand_raw(), 1'($urandom_range(1)),
                     SIZE_W'($urandom_range(SIZE_MAX)), SIZE_W'($urandom_range(SIZE_MAX)),
                     LONG_W'($urandom_range(LONG_MAX)));
      gen_traffic(105);
      drain();

      // back to the power-up calibration
      req_idle_pct = 40;
      rsp_idle_pct = 40;
      apply_settings(tcre_pkg::CAL_MIN_RESET, tcre_pkg::CAL_MAX_RESET,
                     tcre_pkg::CAL_MIN_RESET, tcre_pkg::CAL_MAX_RESET,
                     tcre_pkg::SWAP_RESET, tcre_pkg::WIDTH_RESET,
                     tcre_pkg::HEIGHT_RESET, tcre_pkg::LONG_RESET);
      gen_traffic(105);
      drain();

      // closing stretch at full rate
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      apply_settings(RAW_W'($urandom_range(600)), RAW_W'($urandom_range(3500, RAW_MAX)),
                     RAW_W'($urandom_range(600)), RAW_W'($urandom_range(3500, RAW_MAX)),
                     1'($urandom_range(1)), SIZE_W'($urandom_range(1, SIZE_MAX)),
                     SIZE_W'($urandom_range(1, SIZE_MAX)), LONG_W'($urandom_range(2000)));
      gen_traffic(105);
      drain();

      if (mismatches == 0)
         $display("touch_calibrate_and_release_event_top: match");
      else
         $display("touch_calibrate_and_release_event_top: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
design/tcre_pkg.sv
design/tcre_div.sv
design/tcre_ctrl.sv
design/tcre_datapath.sv
design/touch_calibrate_and_release_event_top.sv
dv/tb.sv
